// ===== hw/rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// Types, register indexes and reset values shared by the gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH     = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam csr_index_type CSR_DEBOUNCE      = 3'd0;
   localparam csr_index_type CSR_SHORT_MAX     = 3'd1;
   localparam csr_index_type CSR_LONG_MAX      = 3'd2;
   localparam csr_index_type CSR_VERY_LONG_MAX = 3'd3;
   localparam csr_index_type CSR_DOUBLE_WINDOW = 3'd4;

   localparam csr_data_type DEBOUNCE_RESET      = 16'd782;
   localparam csr_data_type SHORT_MAX_RESET     = 16'd3906;
   localparam csr_data_type LONG_MAX_RESET      = 16'd31250;
   localparam csr_data_type VERY_LONG_MAX_RESET = 16'd62500;
   localparam csr_data_type DOUBLE_WINDOW_RESET = 16'd10937;

   typedef enum logic [2:0] {
      GESTURE_NONE   = 3'd0,
      GESTURE_SINGLE = 3'd1,
      GESTURE_LONG   = 3'd2,
      GESTURE_VLONG  = 3'd3,
      GESTURE_XLONG  = 3'd4,
      GESTURE_DOUBLE = 3'd5
   } gesture_type;

endpackage

// ===== hw/rtl/button_gesture_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_gesture_classifier_core
// Debounces a ticked button level and classifies clicks by hold time.
// ----------------------------------------------------------------------------
// One transfer on req_ is one timer tick carrying the raw pin level
// (0 pressed, 1 released); every tick gives exactly one transfer on rsp_
// with the gesture seen on that tick and the debounced held state. The
// block takes one tick per cycle while rsp_ is not stalled. A tick passes
// the input register, then the result register, where the state update
// and classification happen in a single pass of compares and saturating
// increments. rsp_stall backs up into req_stall only when both registers
// are full. Hold, lockout and double-click counters are COUNT_WIDTH bits
// and saturate at their top value. The five threshold registers are
// written through csr_ only while no tick is in flight, a rule for the
// user that the block does not enforce; higher indexes are ignored.
// ----------------------------------------------------------------------------
module button_gesture_classifier_core #(
   parameter int COUNT_WIDTH = bgc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // tick input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_button_level,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_gesture,
   output logic                   rsp_button_held,
   // register writes
   input  logic                   csr_write_enable,
   input  bgc_pkg::csr_index_type csr_index,
   input  bgc_pkg::csr_data_type  csr_write_data
);
   import bgc_pkg::*;

   // compare width covers both the counters and the 16-bit thresholds
   localparam int CMP_W = (COUNT_WIDTH > CSR_DATA_WIDTH) ? COUNT_WIDTH : CSR_DATA_WIDTH;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CMP_W-1:0]       cmp_type;

   // threshold registers
   csr_data_type debounce_ff, short_max_ff, long_max_ff, very_long_max_ff, window_max_ff;

   // input register
   logic in_valid_ff;
   logic in_level_ff;

   // result register
   logic        out_valid_ff;
   gesture_type out_gesture_ff, out_gesture_in;
   logic        out_held_ff;

   // classifier state
   logic      held_ff, held_in;
   logic      lock_act_ff, lock_act_in;
   count_type lock_cnt_ff, lock_cnt_in;
   count_type press_cnt_ff, press_cnt_in;
   logic      first_ff, first_in;
   logic      second_ff, second_in;
   count_type win_cnt_ff, win_cnt_in;

   logic advance;     // result register can take a new value
   logic step;        // a tick moves from input to result register

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid       = out_valid_ff;
   assign rsp_gesture     = out_gesture_ff;
   assign rsp_button_held = out_held_ff;

   // ---- register writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         short_max_ff     <= SHORT_MAX_RESET;
         long_max_ff      <= LONG_MAX_RESET;
         very_long_max_ff <= VERY_LONG_MAX_RESET;
         window_max_ff    <= DOUBLE_WINDOW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE:      debounce_ff      <= csr_write_data;
            CSR_SHORT_MAX:     short_max_ff     <= csr_write_data;
            CSR_LONG_MAX:      long_max_ff      <= csr_write_data;
            CSR_VERY_LONG_MAX: very_long_max_ff <= csr_write_data;
            CSR_DOUBLE_WINDOW: window_max_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---- one tick of classification ----
   always_comb begin
      logic      short_click;
      cmp_type   press_x;
      cmp_type   win_x;
      press_cnt_in   = press_cnt_ff;
      lock_cnt_in    = lock_cnt_ff;
      win_cnt_in     = win_cnt_ff;
      held_in        = held_ff;
      lock_act_in    = lock_act_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      out_gesture_in = GESTURE_NONE;
      short_click    = 1'b0;

      // saturating advance of the running counters
      if (held_ff && press_cnt_ff != '1) press_cnt_in = press_cnt_ff + 1'b1;
      if (lock_act_ff && lock_cnt_ff != '1) lock_cnt_in = lock_cnt_ff + 1'b1;
      if (first_ff && win_cnt_ff != '1) win_cnt_in = win_cnt_ff + 1'b1;

      // lockout ends once the debounce time is reached
      if (lock_act_ff && cmp_type'(lock_cnt_in) >= cmp_type'(debounce_ff)) begin
         lock_act_in = 1'b0;
      end

      press_x = cmp_type'(press_cnt_in);
      if (!lock_act_in) begin
         if (!held_ff && !in_level_ff) begin
            // press edge
            held_in      = 1'b1;
            press_cnt_in = '0;
            lock_act_in  = 1'b1;
            lock_cnt_in  = '0;
         end else if (held_ff && in_level_ff) begin
            // release edge: classify the hold time
            held_in     = 1'b0;
            lock_act_in = 1'b1;
            lock_cnt_in = '0;
            priority if (press_x <= cmp_type'(short_max_ff))     short_click    = 1'b1;
            else if (press_x <= cmp_type'(long_max_ff))          out_gesture_in = GESTURE_LONG;
            else if (press_x <= cmp_type'(very_long_max_ff))     out_gesture_in = GESTURE_VLONG;
            else                                                 out_gesture_in = GESTURE_XLONG;
         end
      end

      if (short_click) begin
         if (!first_ff) begin
            first_in   = 1'b1;
            win_cnt_in = '0;
         end else begin
            second_in = 1'b1;
         end
      end

      // double-click window; a long-type release takes this tick
      win_x = cmp_type'(win_cnt_in);
      if (out_gesture_in == GESTURE_NONE && first_in) begin
         if (second_in) begin
            out_gesture_in = (win_x <= cmp_type'(window_max_ff)) ? GESTURE_DOUBLE
                                                                 : GESTURE_SINGLE;
            first_in  = 1'b0;
            second_in = 1'b0;
         end else if (win_x >= cmp_type'(window_max_ff)) begin
            out_gesture_in = GESTURE_SINGLE;
            first_in       = 1'b0;
         end
      end
   end

   // ---- control and state registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_ff      <= 1'b0;
         lock_act_ff  <= 1'b0;
         lock_cnt_ff  <= '0;
         press_cnt_ff <= '0;
         first_ff     <= 1'b0;
         second_ff    <= 1'b0;
         win_cnt_ff   <= '0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= in_valid_ff;
         if (step) begin
            held_ff      <= held_in;
            lock_act_ff  <= lock_act_in;
            lock_cnt_ff  <= lock_cnt_in;
            press_cnt_ff <= press_cnt_in;
            first_ff     <= first_in;
            second_ff    <= second_in;
            win_cnt_ff   <= win_cnt_in;
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) in_level_ff <= req_button_level;
      if (step) begin
         out_gesture_ff <= out_gesture_in;
         out_held_ff    <= held_in;
      end
   end

`ifndef SYNTHESIS
   // a pending second click always has its first
   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> first_ff)
      else $error("second short click flag set without first");

   // only defined gesture codes leave the block
   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_gesture_ff <= GESTURE_DOUBLE))
      else $error("undefined gesture code");

   // every accepted edge starts a lockout
   a_edge_locks: assert property (@(posedge clock) disable iff (reset)
      ($rose(held_ff) || $fell(held_ff)) |-> lock_act_ff)
      else $error("edge accepted without lockout");

   // state changes only when a tick moves through
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(held_ff) && $stable(first_ff) && $stable(press_cnt_ff)))
      else $error("classifier state changed without a tick");

   // result shown matches the debounced state
   a_held_matches: assert property (@(posedge clock) disable iff (reset)
      step |=> (out_held_ff == held_ff))
      else $error("reported held state differs from state register");
`endif

endmodule

// ===== test/button_gesture_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// button_gesture_classifier_core_tb
// Self-checking bench for the debounced click and gesture classifier.
// ----------------------------------------------------------------------------
// Sends timer ticks with a raw button level over req_ and predicts the
// gesture and debounced held state of every tick. Results from rsp_ are
// checked in order against the predictions. The bench runs a short set of
// hand-built click sequences and some corner cases. It then runs phases
// of random click trains under several threshold settings, and ends with
// a long hold under a lengthy lockout that lands in the very long class.
// Both sides idle at random between transfers, bar some random phases and
// the long hold. Thresholds change only while nothing is in flight.
// ----------------------------------------------------------------------------
module button_gesture_classifier_core_tb;
   import bgc_pkg::*;

   localparam int CW          = COUNT_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_TICKS = 200;
   localparam int NUM_PHASES  = 8;
   localparam logic PRESSED   = 1'b0;
   localparam logic RELEASED  = 1'b1;
   localparam logic [CW-1:0] COUNT_TOP = '1;

   typedef struct packed {
      gesture_type gesture;
      logic        held;
   } tick_result_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic          req_button_level;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [2:0]    rsp_gesture;
   logic          rsp_button_held;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;

   // Expected result of every accepted tick, oldest first.
   tick_result_type pending_gestures[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  ticks_sent  = 0;
   // Random idling switches for the sender and the receiver.
   bit  sender_idling   = 1'b1;
   bit  receiver_idling = 1'b1;

   // Shadow copy of the thresholds.
   csr_data_type debounce_limit;
   csr_data_type short_limit;
   csr_data_type long_limit;
   csr_data_type very_long_limit;
   csr_data_type window_limit;

   // Shadow copy of the classifier state.
   logic          held_state;
   logic          lockout_active;
   logic [CW-1:0] lockout_count;
   logic [CW-1:0] press_count;
   logic          first_short_seen;
   logic          second_short_seen;
   logic [CW-1:0] window_count;

   button_gesture_classifier_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gesture      (rsp_gesture),
      .rsp_button_held  (rsp_button_held),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // One tick of the classifier. Counters saturate; the lockout is
   // resolved before edges, and double-click logic runs last.
   function automatic void classify_tick(input logic released,
                                         output gesture_type gesture,
                                         output logic held);
      logic short_click;
      gesture     = GESTURE_NONE;
      short_click = 1'b0;
      if (held_state && press_count != COUNT_TOP) press_count++;
      if (lockout_active && lockout_count != COUNT_TOP) lockout_count++;
      if (first_short_seen && window_count != COUNT_TOP) window_count++;
      if (lockout_active && lockout_count >= debounce_limit) lockout_active = 1'b0;

      if (!lockout_active) begin
         if (!held_state && !released) begin
            held_state     = 1'b1;
            press_count    = '0;
            lockout_active = 1'b1;
            lockout_count  = '0;
         end else if (held_state && released) begin
            held_state     = 1'b0;
            lockout_active = 1'b1;
            lockout_count  = '0;
            if (press_count <= short_limit) short_click = 1'b1;
            else if (press_count <= long_limit) gesture = GESTURE_LONG;
            else if (press_count <= very_long_limit) gesture = GESTURE_VLONG;
            else gesture = GESTURE_XLONG;
         end
      end

      if (short_click) begin
         if (!first_short_seen) begin
            first_short_seen = 1'b1;
            window_count     = '0;
         end else begin
            second_short_seen = 1'b1;
         end
      end

      // A long-type release on the expiry tick pushes the single click
      // out by one tick, since only one gesture goes out per tick.
      if (gesture == GESTURE_NONE && first_short_seen) begin
         if (second_short_seen) begin
            gesture = (window_count <= window_limit) ? GESTURE_DOUBLE : GESTURE_SINGLE;
            first_short_seen  = 1'b0;
            second_short_seen = 1'b0;
         end else if (window_count >= window_limit) begin
            gesture          = GESTURE_SINGLE;
            first_short_seen = 1'b0;
         end
      end
      held = held_state;
   endfunction

   // One tick transfer on req_, with a random gap in front of it.
   task automatic send_tick(input logic level);
      int              gap;
      tick_result_type result;
      gap = sender_idling ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_button_level <= level;
      do @(posedge clock); while (req_stall);
      classify_tick(level, result.gesture, result.held);
      pending_gestures.push_back(result);
      ticks_sent++;
   endtask

   task automatic send_run(input int count, input logic level);
      repeat (count) send_tick(level);
   endtask

   // Hold off the sender until every result is back, plus a short margin
   // for the two-stage pipe.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_gestures.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_register(input csr_index_type index, input csr_data_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         CSR_DEBOUNCE:      debounce_limit  = value;
         CSR_SHORT_MAX:     short_limit     = value;
         CSR_LONG_MAX:      long_limit      = value;
         CSR_VERY_LONG_MAX: very_long_limit = value;
         CSR_DOUBLE_WINDOW: window_limit    = value;
         default: ;
      endcase
   endtask

   task automatic set_thresholds(input csr_data_type debounce, input csr_data_type short_max,
                                 input csr_data_type long_max, input csr_data_type very_long_max,
                                 input csr_data_type window);
      write_register(CSR_DEBOUNCE, debounce);
      write_register(CSR_SHORT_MAX, short_max);
      write_register(CSR_LONG_MAX, long_max);
      write_register(CSR_VERY_LONG_MAX, very_long_max);
      write_register(CSR_DOUBLE_WINDOW, window);
      csr_write_enable <= 1'b0;
   endtask

   // Reset thresholds: a press goes through, and bounce inside the long
   // lockout is ignored.
   task automatic test_reset_values();
      send_run(2, RELEASED);
      send_tick(PRESSED);
      send_tick(RELEASED);
      send_tick(PRESSED);
      send_run(2, RELEASED);
      send_tick(PRESSED);
      wait_for_results();
   endtask

   // Every gesture at the tightest thresholds: single, double, long,
   // very long and extra long.
   task automatic test_gestures();
      set_thresholds(16'd0, 16'd1, 16'd2, 16'd3, 16'd3);
      send_run(1, PRESSED); send_run(4, RELEASED);
      send_run(1, PRESSED); send_run(1, RELEASED);
      send_run(1, PRESSED); send_run(4, RELEASED);
      send_run(2, PRESSED); send_run(1, RELEASED);
      send_run(3, PRESSED); send_run(1, RELEASED);
      send_run(4, PRESSED); send_run(4, RELEASED);
      wait_for_results();
   endtask

   task automatic test_corner_cases();
      // writes past the last register are dropped
      write_register(csr_index_type'($urandom_range(CSR_DOUBLE_WINDOW + 1,
                                                    {CSR_INDEX_WIDTH{1'b1}})),
                     csr_data_type'($urandom_range(0, 16'hFFFF)));
      // long release lands on the window expiry tick
      set_thresholds(16'd0, 16'd1, 16'd100, 16'd200, 16'd6);
      send_run(1, PRESSED); send_run(1, RELEASED);
      send_run(5, PRESSED); send_run(3, RELEASED);
      wait_for_results();
      // zero window: the single click comes on the release tick
      set_thresholds(16'd0, 16'd1, 16'd2, 16'd3, 16'd0);
      send_run(1, PRESSED); send_run(2, RELEASED);
      wait_for_results();
      // window shrinks under a pending click: the second click is late
      set_thresholds(16'd0, 16'd1, 16'd2, 16'd3, 16'd20);
      send_run(1, PRESSED); send_run(1, RELEASED);
      send_run(1, PRESSED);
      wait_for_results();
      write_register(CSR_DOUBLE_WINDOW, 16'd1);
      csr_write_enable <= 1'b0;
      send_run(2, RELEASED);
      wait_for_results();
   endtask

   // Random click trains: presses and gaps sized around the thresholds,
   // optional bounce inside the lockout, and now and then plain noise.
   task automatic test_random_clicks();
      int   phase;
      int   phase_start;
      int   kind;
      int   hold;
      int   gap;
      int   hold_cap;
      int   gap_cap;
      int   lo;
      int   mid;
      logic bouncy;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         sender_idling   = (phase != 3 && phase != 6);
         receiver_idling = (phase != 4 && phase != 6);
         case (phase)
            0: set_thresholds(16'd0, 16'd2, 16'd5, 16'd9, 16'd0);
            1: set_thresholds(csr_data_type'($urandom_range(0, 4)), 16'hFFFF, 16'hFFFF,
                              16'hFFFF, csr_data_type'($urandom_range(0, 30)));
            2: set_thresholds(csr_data_type'($urandom_range(1, 6)),
                              csr_data_type'($urandom_range(1, 30)),
                              csr_data_type'($urandom_range(1, 30)),
                              csr_data_type'($urandom_range(1, 30)),
                              csr_data_type'($urandom_range(1, 30)));
            default: begin
               lo  = $urandom_range(1, 12);
               mid = lo + $urandom_range(0, 12);
               set_thresholds(csr_data_type'($urandom_range(0, 6)), csr_data_type'(lo),
                              csr_data_type'(mid),
                              csr_data_type'(mid + $urandom_range(0, 12)),
                              csr_data_type'($urandom_range(0, 25)));
            end
         endcase
         hold_cap = (very_long_limit < 56) ? very_long_limit + 4 : 60;
         gap_cap  = window_limit + debounce_limit + 4;
         if (gap_cap > 60) gap_cap = 60;
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < PHASE_TICKS) begin
            kind = $urandom_range(0, 7);
            if (kind == 0) begin
               repeat ($urandom_range(1, 10)) send_tick(logic'($urandom_range(0, 1)));
            end else begin
               hold   = $urandom_range(1, hold_cap);
               gap    = $urandom_range(1, gap_cap);
               bouncy = logic'($urandom_range(0, 1));
               for (int i = 0; i < hold; i++)
                  send_tick((bouncy && i > 0 && i < debounce_limit) ?
                            logic'($urandom_range(0, 1)) : PRESSED);
               for (int i = 0; i < gap; i++)
                  send_tick((bouncy && i > 0 && i < debounce_limit) ?
                            logic'($urandom_range(0, 1)) : RELEASED);
            end
         end
         // sender holds off here until the result queue runs dry
         wait_for_results();
      end
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
   endtask

   // A long hold under a lengthy lockout: the hold passes the long limit
   // and falls under the top-of-range very long limit.
   task automatic test_long_hold();
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      set_thresholds(16'd50, 16'd40, 16'd150, 16'hFFFF, 16'hFFFF);
      send_run(200, PRESSED);
      send_run(60, RELEASED);
      wait_for_results();
   endtask

   // Result side: draw a stall length for each result transfer.
   initial begin : result_backpressure
      int hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = receiver_idling ? $urandom_range(0, 16) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Result check: each transfer on rsp_ against the oldest prediction.
   always @(posedge clock) begin : result_check
      tick_result_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gestures.size() == 0) begin
            $error("rsp_ transfer with nothing expected: gesture %0d held %0d",
                   rsp_gesture, rsp_button_held);
            error_count++;
         end else begin
            expected = pending_gestures.pop_front();
            if (rsp_gesture !== expected.gesture) begin
               $error("rsp_gesture: expected %0d, actual %0d", expected.gesture, rsp_gesture);
               error_count++;
            end
            if (rsp_button_held !== expected.held) begin
               $error("rsp_button_held: expected %0d, actual %0d",
                      expected.held, rsp_button_held);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_button_level <= RELEASED;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_DEBOUNCE;
      csr_write_data   <= '0;
      debounce_limit    = DEBOUNCE_RESET;
      short_limit       = SHORT_MAX_RESET;
      long_limit        = LONG_MAX_RESET;
      very_long_limit   = VERY_LONG_MAX_RESET;
      window_limit      = DOUBLE_WINDOW_RESET;
      held_state        = 1'b0;
      lockout_active    = 1'b0;
      lockout_count     = '0;
      press_count       = '0;
      first_short_seen  = 1'b0;
      second_short_seen = 1'b0;
      window_count      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_gestures();
      test_corner_cases();
      test_random_clicks();
      test_long_hold();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
